[src/cln_pkg.sv]
// Shared types, codes and byte constants of the configuration line normalizer.
package cln_pkg;

  localparam int unsigned ArgWidth = 4;
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;
  localparam logic [0:0] RegArgCount = 1'b0;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChVtab = 8'h0b;
  localparam logic [7:0] ChFeed = 8'h0c;
  localparam logic [7:0] ChReturn = 8'h0d;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef enum logic [0:0] {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_LINE_END = 3'd1,
    ST_NO_INPUT = 3'd2,
    ST_BAD_SEQ  = 3'd3,
    ST_BAD_ARG  = 3'd4,
    ST_NESTED   = 3'd5,
    ST_SUBST    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  typedef struct packed {
    status_t               status;
    logic [7:0]            out_byte;
    logic [ArgWidth-1:0]   arg_index;
    logic                  last;
  } result_t;

  function automatic logic is_white(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChVtab || c == ChFeed || c == ChReturn;
  endfunction

endpackage

[src/cln_stream_if.sv]
// Handshake channels for input beats and result beats of the normalizer.
interface cln_item_if import cln_pkg::*;;
  logic       valid;
  logic       ready;
  command_t   command;
  logic [7:0] data_byte;
  logic       from_argument;

  modport source (output valid, command, data_byte, from_argument, input ready);
  modport sink (input valid, command, data_byte, from_argument, output ready);
endinterface

interface cln_result_if import cln_pkg::*;;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [7:0]          out_byte;
  logic [ArgWidth-1:0] arg_index;
  logic                last;

  modport source (output valid, status, out_byte, arg_index, last, input ready);
  modport sink (input valid, status, out_byte, arg_index, last, output ready);
endinterface

[src/config_line_normalizer.sv]
// Configuration line normalizer: one input byte per unstalled cycle, two-beat result buffer.
//
// While result.ready holds, the block takes one input beat per cycle and its
// buffer drains one result beat per cycle. Each beat updates the line state
// in the same cycle and loads zero, one or two results into the two-entry
// buffer. Input is ready while the buffer is empty or its last waiting beat
// leaves in this cycle, so beats that yield one result sustain that rate, and
// one releasing a held space with a byte fills both entries and stalls input
// until the space leaves. arg_count is written over APB at byte address 0.
module config_line_normalizer import cln_pkg::*; #(
  parameter int unsigned AW = PaddrWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  cln_item_if.sink              item,
  cln_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AW-1:0]         paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  logic [ArgWidth-1:0] arg_count;
  logic                reg_hit;

  mode_t mode, mode_next;
  logic  escape_pending, escape_pending_next;
  logic  space_pending, space_pending_next;
  logic  line_nonempty, line_nonempty_next;
  logic  percent_seen, percent_seen_next;

  result_t     slot0, slot1;
  logic [1:0]  cnt;

  logic        push, pop;
  logic        do_take, do_finish, emit_byte, emit_space;
  logic [7:0]  take_c, c_raw;
  status_t     fin_status;
  logic [ArgWidth-1:0] fin_idx, digit;
  logic        is_digit;
  result_t     r_main, r_space;

  assign pready = 1'b1;
  assign reg_hit = paddr[AW-1:2] == (AW-2)'(RegArgCount);
  assign prdata = reg_hit ? PdataWidth'(arg_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_count <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      arg_count <= pwdata[ArgWidth-1:0];
    end
  end

  assign pop = result.valid && result.ready;
  assign item.ready = (cnt == 2'd0) || (cnt == 2'd1 && result.ready);
  assign push = item.valid && item.ready;

  assign c_raw = (item.data_byte == ChNewline) ? 8'h00 : item.data_byte;
  assign is_digit = c_raw >= ChZero && c_raw <= ChNine;
  assign digit = c_raw[ArgWidth-1:0];

  always_comb begin
    mode_next = mode;
    escape_pending_next = escape_pending;
    space_pending_next = space_pending;
    line_nonempty_next = line_nonempty;
    percent_seen_next = percent_seen;
    do_take = 1'b0;
    take_c = c_raw;
    do_finish = 1'b0;
    fin_status = ST_LINE_END;
    fin_idx = '0;
    emit_byte = 1'b0;
    emit_space = 1'b0;

    if (item.command == CMD_END) begin
      take_c = 8'h00;
      if (!line_nonempty) begin
        do_finish = 1'b1;
        fin_status = ST_NO_INPUT;
      end else if (percent_seen || mode == MODE_STRING) begin
        do_finish = 1'b1;
        fin_status = ST_BAD_SEQ;
      end else begin
        do_take = 1'b1;
      end
    end else if (!(item.from_argument && item.data_byte == 8'h00)) begin
      if (percent_seen) begin
        percent_seen_next = 1'b0;
        if (c_raw == 8'h00) begin
          do_finish = 1'b1;
          fin_status = ST_BAD_SEQ;
        end else if (c_raw == ChPercent) begin
          do_take = 1'b1;
        end else if (!is_digit || digit >= arg_count) begin
          do_finish = 1'b1;
          fin_status = ST_BAD_ARG;
        end else if (item.from_argument) begin
          do_finish = 1'b1;
          fin_status = ST_NESTED;
        end else begin
          do_finish = 1'b1;
          fin_status = ST_SUBST;
          fin_idx = digit;
        end
      end else if (c_raw == 8'h00 && mode == MODE_STRING) begin
        do_finish = 1'b1;
        fin_status = ST_BAD_SEQ;
      end else if (c_raw == ChPercent) begin
        percent_seen_next = 1'b1;
      end else begin
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      if (mode == MODE_COMMENT) begin
        if (take_c == 8'h00) begin
          do_finish = 1'b1;
          fin_status = ST_LINE_END;
        end
      end else if (mode == MODE_STRING) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else begin
          if (take_c == ChBackslash) escape_pending_next = 1'b1;
          if (take_c == ChQuote) mode_next = MODE_NORMAL;
        end
        line_nonempty_next = 1'b1;
        emit_byte = 1'b1;
      end else if (is_white(take_c)) begin
        if (line_nonempty) space_pending_next = 1'b1;
      end else if (take_c == ChHash) begin
        mode_next = MODE_COMMENT;
      end else if (take_c == 8'h00) begin
        do_finish = 1'b1;
        fin_status = ST_LINE_END;
      end else begin
        if (take_c == ChQuote) mode_next = MODE_STRING;
        emit_space = space_pending;
        space_pending_next = 1'b0;
        line_nonempty_next = 1'b1;
        emit_byte = 1'b1;
      end
    end

    if (do_finish && fin_status != ST_SUBST) begin
      mode_next = MODE_NORMAL;
      escape_pending_next = 1'b0;
      space_pending_next = 1'b0;
      line_nonempty_next = 1'b0;
      percent_seen_next = 1'b0;
    end

    r_main.status = do_finish ? fin_status : ST_BYTE;
    r_main.out_byte = do_finish ? 8'h00 : take_c;
    r_main.arg_index = fin_idx;
    r_main.last = 1'b1;
    r_space.status = ST_BYTE;
    r_space.out_byte = ChSpace;
    r_space.arg_index = '0;
    r_space.last = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      escape_pending <= 1'b0;
      space_pending <= 1'b0;
      line_nonempty <= 1'b0;
      percent_seen <= 1'b0;
    end else if (push) begin
      mode <= mode_next;
      escape_pending <= escape_pending_next;
      space_pending <= space_pending_next;
      line_nonempty <= line_nonempty_next;
      percent_seen <= percent_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= emit_space ? 2'd2 : ((emit_byte || do_finish) ? 2'd1 : 2'd0);
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= emit_space ? r_space : r_main;
      slot1 <= r_main;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign result.valid = cnt != 2'd0;
  assign result.status = slot0.status;
  assign result.out_byte = slot0.out_byte;
  assign result.arg_index = slot0.arg_index;
  assign result.last = slot0.last;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt == 2'd0 || pop))
    else $error("input beat taken while result buffer still holds data");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result buffer count out of range");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_BYTE |-> result.last)
    else $error("non-byte result not marked last");

  a_space_needs_text: assert property (@(posedge clk) disable iff (rst)
    space_pending |-> line_nonempty)
    else $error("space held on an empty line");

endmodule
